@@ rtl/vrd_pkg.sv @@
// Package for the vibration detector: widths and reset constants.
// No dependencies.
package vrd_pkg;
  localparam int unsigned AxisW = 16;
  localparam int unsigned MagW  = 16;
  localparam int unsigned SqW   = 34;
  localparam logic [15:0] ThreshReset = 16'd384;
endpackage

@@ rtl/vibration_rms_detector.sv @@
// Vibration detector: windowed standard deviation of acceleration magnitude.
// Depends on vrd_pkg.
// A request squares the axes, takes the root, stores it, walks the window, runs four
// multiplies and compares; below MIN_COUNT entries it skips the walk and multiplies, and an
// invalid sample goes straight to the result. One request at a time; the next is taken only
// after the result is accepted. Reset clears write index, fill flag, threshold (384) and control.
module vibration_rms_detector #(
  parameter int unsigned WINDOW_DEPTH = 32,
  parameter int unsigned MIN_COUNT    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  logic [47:0] s_axis_tdata,
  // tuser: sample_valid
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: vib_high[0], zeros above
  output logic [7:0]  m_axis_tdata
);
  import vrd_pkg::*;

  localparam int unsigned IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned NW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned S1W = MagW + NW;
  localparam int unsigned S2W = 2 * MagW + NW;
  localparam int unsigned PW = 2 * S1W + 2;
  localparam int unsigned MulW = $clog2(PW + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_ROOT, ST_WALK, ST_TAIL, ST_M1, ST_M2, ST_M3, ST_M4, ST_CMP, ST_OUT
  } state_e;

  state_e            state_q;
  logic [15:0]       thr_q;
  logic [IW-1:0]     widx_q;
  logic              full_q;
  logic [15:0]       ax_q, ay_q, az_q;
  logic [SqW-1:0]    sq_q;
  logic [SqW-1:0]    rem_q;
  logic [MagW:0]     root_q;
  logic [4:0]        cnt_q;
  logic [NW-1:0]     n_q;
  logic [NW-1:0]     ri_q;
  logic              rv_q;
  logic [MagW-1:0]   rd_q;
  logic [S1W-1:0]    s1_q;
  logic [S2W-1:0]    s2_q;
  logic [PW-1:0]     ma_q, mp_q, lhs_q;
  logic [PW-1:0]     mb_q;
  logic [MulW-1:0]   mc_q;
  logic              vib_q;
  logic [MagW-1:0]   mem [WINDOW_DEPTH];

  // Square of one axis magnitude, one axis per cycle
  logic [15:0] axis_abs;
  logic [31:0] axis_sq;
  assign axis_abs = ax_q[15] ? (16'd0 - ax_q) : ax_q;
  assign axis_sq  = axis_abs * axis_abs;

  // Restoring root: one result bit per cycle
  logic [SqW-1:0] trial;
  logic [SqW-1:0] rem_sh;
  assign rem_sh = {rem_q[SqW-3:0], sq_q[SqW-1 -: 2]};
  assign trial  = {{(SqW-MagW-3){1'b0}}, root_q, 2'b01};

  logic [MagW:0] mag_sat;
  assign mag_sat = root_q;

  // Square of the entry read during the walk
  logic [2*MagW-1:0] rd_sq;
  assign rd_sq = rd_q * rd_q;

  // Square of the fill count
  logic [2*NW-1:0] n_sq;
  assign n_sq = n_q * n_q;

  // Fill count after the new entry is stored
  logic [NW-1:0] n_next;
  assign n_next = (full_q || widx_q == IW'(WINDOW_DEPTH - 1)) ? NW'(WINDOW_DEPTH)
                                                                : NW'({1'b0, widx_q} + 1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {7'd0, vib_q};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_TAIL) begin
      mem[widx_q] <= (mag_sat[MagW]) ? {MagW{1'b1}} : mag_sat[MagW-1:0];
    end
    rd_q <= mem[ri_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q   <= ThreshReset;
      widx_q  <= '0;
      full_q  <= 1'b0;
      vib_q   <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            ax_q <= s_axis_tdata[15:0];
            ay_q <= s_axis_tdata[31:16];
            az_q <= s_axis_tdata[47:32];
            sq_q <= '0;
            cnt_q <= 5'd0;
            vib_q <= 1'b0;
            state_q <= s_axis_tuser ? ST_SQ : ST_OUT;
          end
        end
        // accumulate three squares, rotating axes
        ST_SQ: begin
          sq_q <= sq_q + {{(SqW-32){1'b0}}, axis_sq};
          ax_q <= ay_q;
          ay_q <= az_q;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd2) begin
            rem_q <= '0;
            root_q <= '0;
            cnt_q <= 5'd0;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          sq_q <= {sq_q[SqW-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_q <= rem_sh - trial;
            root_q <= {root_q[MagW-1:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            root_q <= {root_q[MagW-1:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(SqW/2 - 1)) begin
            state_q <= ST_TAIL;
          end
        end
        // write new entry, update index, start walk (or go to output below MIN_COUNT entries)
        ST_TAIL: begin
          s1_q <= '0;
          s2_q <= '0;
          ri_q <= '0;
          rv_q <= 1'b0;
          if (widx_q == IW'(WINDOW_DEPTH - 1)) begin
            widx_q <= '0;
            full_q <= 1'b1;
            n_q <= NW'(WINDOW_DEPTH);
          end else begin
            widx_q <= widx_q + 1'b1;
            n_q <= full_q ? NW'(WINDOW_DEPTH) : NW'({1'b0, widx_q} + 1);
          end
          state_q <= ST_WALK;
          if (32'(n_next) < MIN_COUNT) begin
            state_q <= ST_OUT;
          end
        end
        // one entry per cycle; read data is registered and lags the address
        ST_WALK: begin
          if (rv_q) begin
            s1_q <= s1_q + S1W'(rd_q);
            s2_q <= s2_q + S2W'(rd_sq);
          end
          if (ri_q == n_q) begin
            rv_q <= 1'b0;
            if (!rv_q) begin
              ma_q <= PW'(n_q);
              mb_q <= PW'(s2_q);
              mp_q <= '0;
              mc_q <= '0;
              state_q <= ST_M1;
            end
          end else begin
            ri_q <= ri_q + 1'b1;
            rv_q <= 1'b1;
          end
        end
        // shift-add multiplies: n*S2, S1*S1, T*T, then (T*T)*(n*n)
        ST_M1, ST_M2, ST_M3, ST_M4: begin
          if (mb_q[0]) begin
            mp_q <= mp_q + ma_q;
          end
          ma_q <= {ma_q[PW-2:0], 1'b0};
          mb_q <= {1'b0, mb_q[PW-1:1]};
          mc_q <= mc_q + 1'b1;
          if (mc_q == MulW'(PW - 1)) begin
            mc_q <= '0;
            unique case (state_q)
              ST_M1: begin
                lhs_q <= mp_q + (mb_q[0] ? ma_q : '0);
                ma_q <= PW'(s1_q);
                mb_q <= PW'(s1_q);
                mp_q <= '0;
                state_q <= ST_M2;
              end
              ST_M2: begin
                sq_q <= '0;
                lhs_q <= (lhs_q > (mp_q + (mb_q[0] ? ma_q : '0)))
                         ? lhs_q - (mp_q + (mb_q[0] ? ma_q : '0)) : '0;
                ma_q <= PW'(thr_q);
                mb_q <= PW'(thr_q);
                mp_q <= '0;
                state_q <= ST_M3;
              end
              ST_M3: begin
                ma_q <= PW'(n_sq);
                mb_q <= mp_q + (mb_q[0] ? ma_q : '0);
                mp_q <= '0;
                state_q <= ST_M4;
              end
              default: begin
                mp_q <= mp_q + (mb_q[0] ? ma_q : '0);
                state_q <= ST_CMP;
              end
            endcase
          end
        end
        ST_CMP: begin
          vib_q <= (lhs_q > mp_q);
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
